/* rtl/rse_pkg.sv */
package rse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_DIGIT   = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_MULTI   = 3'd5,
        OP_UNKNOWN = 3'd6,
        OP_END     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MULTI    = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_FEW      = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_STRUCT   = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_ARITH,
        CLS_ERROR,
        CLS_END
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        op_t         op;
        logic [3:0]  dig;
        status_t     err;
    } tok_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_END_RD,
        EX_RD_B,
        EX_RD_A,
        EX_EXEC,
        EX_WAIT_MUL,
        EX_WAIT_DIV
    } ex_state_t;

    function automatic logic [63:0] magnitude(input logic [63:0] raw);
        magnitude = raw[63] ? (64'd0 - raw) : raw;
    endfunction

    // Saturated two's complement value from a sign and a wide magnitude.
    function automatic logic [63:0] from_mag(input logic neg, input logic hi_nz,
                                             input logic [63:0] lo);
        if (neg) begin
            if (hi_nz || lo > NEG_MAX)
                from_mag = NEG_MAX;
            else
                from_mag = 64'd0 - lo;
        end
        else begin
            if (hi_nz || lo > POS_MAX)
                from_mag = POS_MAX;
            else
                from_mag = lo;
        end
    endfunction

endpackage

/* rtl/rse_front.sv */
module rse_front
    import rse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] opcode,
    input  logic [3:0] digit,
    output logic       head_valid,
    output tok_t       head,
    input  logic       head_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tok_t            q_mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    tok_t            tok_in;
    logic            do_push, do_pop;

    // Classify the token on the way in so the back end decodes little.
    always_comb
    begin
        tok_in.op  = op_t'(opcode);
        tok_in.dig = digit;
        tok_in.err = ST_OK;
        case (op_t'(opcode))
            OP_DIGIT:   tok_in.cls = CLS_DIGIT;
            OP_ADD,
            OP_SUB,
            OP_MUL,
            OP_DIV:     tok_in.cls = CLS_ARITH;
            OP_MULTI:
            begin
                tok_in.cls = CLS_ERROR;
                tok_in.err = ST_MULTI;
            end
            OP_UNKNOWN:
            begin
                tok_in.cls = CLS_ERROR;
                tok_in.err = ST_UNKNOWN;
            end
            default:    tok_in.cls = CLS_END;
        endcase
    end

    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= tok_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

/* rtl/rse_mul.sv */
module rse_mul
    import rse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic           busy_reg, fin_reg, done_reg, neg_reg;
    logic [2:0]     cnt_reg;
    logic [63:0]    am_reg, bm_reg, result_reg;
    logic [63:0]    pp_reg;
    logic [1:0]     sh_reg;
    logic [127:0]   acc_reg, pp_shifted, acc_shifted;
    logic [31:0]    a_part, b_part;

    // Four 32 by 32 partial products, one a cycle, each registered and added to the accumulator in the next cycle.
    assign a_part = cnt_reg[0] ? am_reg[63:32] : am_reg[31:0];
    assign b_part = cnt_reg[1] ? bm_reg[63:32] : bm_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign acc_shifted = acc_reg >> FRAC_BITS;
    assign done        = done_reg;
    assign result      = result_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= magnitude(a);
            bm_reg  <= magnitude(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= 64'(a_part) * 64'(b_part);
            sh_reg <= 2'({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]});
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_shifted;
        end
        if (fin_reg)
            result_reg <= from_mag(neg_reg, |acc_shifted[127:64], acc_shifted[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/rse_div.sv */
module rse_div
    import rse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int KW = $clog2(NW);

    logic           busy_reg, fin_reg, done_reg, neg_reg;
    logic [KW-1:0]  cnt_reg;
    logic [NW-1:0]  num_reg, q_reg;
    logic [63:0]    rem_reg, dm_reg, result_reg, rem_try;
    logic           fits;

    // Restoring division, one quotient bit a cycle, numerator MSB first.
    assign rem_try = {rem_reg[62:0], num_reg[NW-1]};
    assign fits    = (rem_try >= dm_reg);
    assign done    = done_reg;
    assign result  = result_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= NW'(magnitude(a)) << FRAC_BITS;
            dm_reg  <= magnitude(b);
            neg_reg <= a[63] ^ b[63];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? (rem_try - dm_reg) : rem_try;
            q_reg   <= {q_reg[NW-2:0], fits};
        end
        if (fin_reg)
            result_reg <= from_mag(neg_reg, |q_reg[NW-1:64], q_reg[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + KW'(1);
                if (cnt_reg == KW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/rse_exec.sv */
module rse_exec
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  tok_t        head,
    output logic        head_pop,
    output logic        out_valid,
    output logic [2:0]  out_status,
    output logic [63:0] out_value,
    input  logic        out_pop
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [63:0]    mem [STACK_DEPTH];
    logic [63:0]    rdata_reg;
    logic [AW-1:0]  rd_addr, mem_wa;
    logic [63:0]    mem_wd;
    logic           mem_we;

    ex_state_t      state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next, cm1, cm2;
    logic           failed_reg, failed_next;
    op_t            op_reg, op_next;
    logic [63:0]    a_reg, a_next, b_reg, b_next;
    logic           out_valid_reg, out_valid_next;
    status_t        out_status_reg, out_status_next;
    logic [63:0]    out_value_reg, out_value_next;

    logic           mul_start, mul_done, div_start, div_done;
    logic [63:0]    mul_result, div_result;

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] s;
        s = x + y;
        if (!(x[63] ^ y[63]) && (x[63] ^ s[63]))
            sat_add = x[63] ? NEG_MAX : POS_MAX;
        else
            sat_add = s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] d;
        d = x - y;
        if ((x[63] ^ y[63]) && (x[63] ^ d[63]))
            sat_sub = x[63] ? NEG_MAX : POS_MAX;
        else
            sat_sub = d;
    endfunction

    rse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (a_reg),
        .b      (b_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    rse_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (a_reg),
        .b      (b_reg),
        .done   (div_done),
        .result (div_result)
    );

    assign cm1        = count_reg - CW'(1);
    assign cm2        = count_reg - CW'(2);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg && !out_pop;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        head_pop        = 1'b0;
        rd_addr         = '0;
        mem_we          = 1'b0;
        mem_wa          = cm2[AW-1:0];
        mem_wd          = '0;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            EX_IDLE:
            begin
                rd_addr = (head.cls == CLS_END) ? '0 : cm1[AW-1:0];
                if (head_valid && !out_valid_reg)
                begin
                    head_pop = 1'b1;
                    op_next  = head.op;
                    if (head.cls == CLS_END)
                    begin
                        if (failed_reg)
                        begin
                            failed_next = 1'b0;
                            count_next  = '0;
                        end
                        else if (count_reg == CW'(1))
                            state_next = EX_END_RD;
                        else
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_STRUCT;
                            out_value_next  = '0;
                        end
                    end
                    else if (!failed_reg)
                    begin
                        case (head.cls)
                            CLS_DIGIT:
                            begin
                                if (count_reg >= CW'(STACK_DEPTH))
                                begin
                                    count_next      = '0;
                                    failed_next     = 1'b1;
                                    out_valid_next  = 1'b1;
                                    out_status_next = ST_OVERFLOW;
                                    out_value_next  = '0;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    mem_wa     = count_reg[AW-1:0];
                                    mem_wd     = 64'(head.dig) << FRAC_BITS;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            CLS_ARITH:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    count_next      = '0;
                                    failed_next     = 1'b1;
                                    out_valid_next  = 1'b1;
                                    out_status_next = ST_FEW;
                                    out_value_next  = '0;
                                end
                                else
                                    state_next = EX_RD_B;
                            end
                            default:
                            begin
                                count_next      = '0;
                                failed_next     = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = head.err;
                                out_value_next  = '0;
                            end
                        endcase
                    end
                end
            end
            EX_END_RD:
            begin
                count_next      = '0;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_value_next  = rdata_reg;
                state_next      = EX_IDLE;
            end
            EX_RD_B:
            begin
                b_next     = rdata_reg;
                rd_addr    = cm2[AW-1:0];
                state_next = EX_RD_A;
            end
            EX_RD_A:
            begin
                a_next     = rdata_reg;
                state_next = EX_EXEC;
            end
            EX_EXEC:
            begin
                state_next = EX_IDLE;
                case (op_reg)
                    OP_ADD:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = sat_add(a_reg, b_reg);
                        count_next = cm1;
                    end
                    OP_SUB:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = sat_sub(a_reg, b_reg);
                        count_next = cm1;
                    end
                    OP_MUL:
                    begin
                        mul_start  = 1'b1;
                        state_next = EX_WAIT_MUL;
                    end
                    default:
                    begin
                        if (b_reg == '0)
                        begin
                            count_next      = '0;
                            failed_next     = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_DIVZERO;
                            out_value_next  = '0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = EX_WAIT_DIV;
                        end
                    end
                endcase
            end
            EX_WAIT_MUL:
            begin
                if (mul_done)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = mul_result;
                    count_next = cm1;
                    state_next = EX_IDLE;
                end
            end
            EX_WAIT_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = div_result;
                    count_next = cm1;
                    state_next = EX_IDLE;
                end
            end
            default:
                state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_IDLE;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_failed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> count_reg == '0)
        else $error("stack not empty while failed");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_pop |=> out_valid_reg && $stable(out_value_reg))
        else $error("waiting result lost or changed");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> state_reg == EX_IDLE && !out_valid_reg)
        else $error("token taken while busy");

    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> state_reg == EX_WAIT_MUL)
        else $error("multiply started without waiting");

endmodule

/* rtl/rpn_stack_evaluator_unit.sv */
// Reverse Polish evaluator over classified tokens, signed fixed point values.
// Input channel: a token item (opcode, digit) is taken when push is high and
// full is low. A four-entry token queue stands in front of the execution
// engine, so the source can keep pushing while a result waits to be popped.
// Result channel: while empty is low the oldest result (status, value) is on
// the ports; it is taken when pop is high. Results appear only for an error
// and for the end marker of an expression that had no error.
// In the execution engine an end marker reads its result, and add and
// subtract read both operands, through the stack memory's registered read
// port; multiply forms four 32 by 32 partial products, one a cycle, and
// divide forms one quotient bit a cycle. Values are Q32.32 at the default
// FRAC_BITS. A new token is taken only once the last one is done.
// After reset the stack is empty and no error is pending; no clearing pass
// is needed. When the receiver does not pop, the waiting result is held and
// the engine stops taking tokens; the queue fills and then full rises.
module rpn_stack_evaluator_unit
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         opcode,
    input  logic [3:0]         digit,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic signed [63:0] value
);

    // Front to back token path.
    logic        head_valid;
    logic        head_pop;
    tok_t        head;
    logic        out_valid;
    logic [63:0] out_value;

    rse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .digit      (digit),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // The engine holds the stack, the error flag and the result register.
    rse_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_status (status),
        .out_value  (out_value),
        .out_pop    (pop)
    );

    assign empty = !out_valid;
    assign value = $signed(out_value);

endmodule
